/* rtl/rgb555_color_envelope_interpolator_core_macros.svh */
// Assertion macros shared by the checker of the color envelope interpolator.
// No dependencies; included by files that hold concurrent assertions.
`ifndef RGB555_COLOR_ENVELOPE_INTERPOLATOR_CORE_MACROS_SVH
`define RGB555_COLOR_ENVELOPE_INTERPOLATOR_CORE_MACROS_SVH

// Same-cycle implication, checked at every clock edge outside reset.
`define RGBENV_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every clock edge outside reset.
`define RGBENV_ASSERT_NXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/rgbenv_pkg.sv */
// Package of the RGB555 color envelope interpolator: widths, register
// indexes, reset values and the stage payload types. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rgbenv_pkg;

  localparam int COLOR_W    = 15;
  localparam int CHAN_W     = 5;
  localparam int NUM_CHAN   = 3;
  localparam int POS_W      = 8;
  localparam int PROD_W     = CHAN_W + POS_W;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 15;
  localparam int PIPE_DEPTH = 4;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_START_COLOR    = 3'd0,
    REG_PEAK_COLOR     = 3'd1,
    REG_END_COLOR      = 3'd2,
    REG_FADE_IN_POINT  = 3'd3,
    REG_PEAK_POINT     = 3'd4,
    REG_FADE_OUT_POINT = 3'd5,
    REG_INTERP_EN      = 3'd6
  } cfg_reg_t;

  // Reset values of the configuration registers.
  localparam logic [COLOR_W-1:0] RST_START_COLOR    = 15'h0000;
  localparam logic [COLOR_W-1:0] RST_PEAK_COLOR     = 15'h7FFF;
  localparam logic [COLOR_W-1:0] RST_END_COLOR      = 15'h0000;
  localparam logic [POS_W-1:0]   RST_FADE_IN_POINT  = 8'd0;
  localparam logic [POS_W-1:0]   RST_PEAK_POINT     = 8'd128;
  localparam logic [POS_W-1:0]   RST_FADE_OUT_POINT = 8'd255;
  localparam logic               RST_INTERP_EN      = 1'b1;

  typedef struct packed {
    logic [COLOR_W-1:0] start_color;
    logic [COLOR_W-1:0] peak_color;
    logic [COLOR_W-1:0] end_color;
    logic [POS_W-1:0]   fade_in_point;
    logic [POS_W-1:0]   peak_point;
    logic [POS_W-1:0]   fade_out_point;
    logic               interp_en;
  } cfg_regs_t;

  // Stage 0 result: the segment endpoints and the position within it.
  typedef struct packed {
    logic [COLOR_W-1:0] base;
    logic [COLOR_W-1:0] target;
    logic [POS_W-1:0]   off;
    logic [POS_W-1:0]   span;
  } phase_data_t;

  // Stage 1 result: per channel sign and magnitude of offset times difference.
  typedef struct packed {
    logic              neg;
    logic [CHAN_W-1:0] base;
    logic [PROD_W-1:0] prod;
  } chan_prod_t;

  typedef struct packed {
    chan_prod_t [NUM_CHAN-1:0] ch;
    logic [POS_W-1:0]          span;
  } mul_data_t;

  // Stage 2 result: partial remainder and upper quotient bits per channel.
  typedef struct packed {
    logic              neg;
    logic [CHAN_W-1:0] base;
    logic [PROD_W-1:0] rem;
    logic [2:0]        q_hi;
  } div_chan_t;

  typedef struct packed {
    div_chan_t [NUM_CHAN-1:0] ch;
    logic [POS_W-1:0]         span;
  } div_data_t;

  // Load enables of the two divider stages.
  typedef struct packed {
    logic s2_en;
    logic s3_en;
  } pipe_ctl_t;

endpackage

`default_nettype wire

/* rtl/rgbenv_if.sv */
// Handshake interfaces of the color envelope interpolator: input item,
// result item and configuration write. Depends on rgbenv_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface rgbenv_in_if;
  import rgbenv_pkg::*;
  logic             valid;
  logic             ready;
  logic [POS_W-1:0] life_position;
  modport source (output valid, output life_position, input ready);
  modport sink (input valid, input life_position, output ready);
endinterface

interface rgbenv_out_if;
  import rgbenv_pkg::*;
  logic               valid;
  logic               ready;
  logic [COLOR_W-1:0] color_out;
  modport source (output valid, output color_out, input ready);
  modport sink (input valid, input color_out, output ready);
endinterface

interface rgbenv_cfg_if;
  import rgbenv_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* rtl/rgb555_color_envelope_interpolator_core.sv */
// Top level of the RGB555 color envelope interpolator: register file,
// four-stage pipeline and its valid/ready control.
// Depends on rgbenv_pkg, rgbenv_if and the rgbenv_* stage modules.
//
//   Port     Role     Payload
//   in_if    sink     life_position  [7:0]
//   out_if   source   color_out      [14:0]
//   cfg_if   sink     index [2:0], data [14:0]
//
// A result is valid once its item has passed four register stages: phase
// select, multiply and two divider stages. One item per cycle while
// out_if is ready. The last divider stage is the output register.
// Each stage holds its item while the one after it is full and stalled;
// a stall loses and repeats nothing. cfg_if is always ready.
// rst_n clears the valid bits and loads the register reset values.
`timescale 1ns / 1ps
`default_nettype none

module rgb555_color_envelope_interpolator_core (
  input  wire           clk,
  input  wire           rst_n,
  rgbenv_in_if.sink     in_if,
  rgbenv_out_if.source  out_if,
  rgbenv_cfg_if.sink    cfg_if
);
  import rgbenv_pkg::*;

  cfg_regs_t   cfg_regs;
  phase_data_t phase_data;
  mul_data_t   mul_data;
  pipe_ctl_t   div_ctl;

  logic s0_valid_r, s1_valid_r, s2_valid_r, s3_valid_r;
  logic s0_rdy, s1_rdy, s2_rdy, s3_rdy;

  // A stage may load when it is empty or its item moves on this cycle.
  assign s3_rdy = !s3_valid_r || out_if.ready;
  assign s2_rdy = !s2_valid_r || s3_rdy;
  assign s1_rdy = !s1_valid_r || s2_rdy;
  assign s0_rdy = !s0_valid_r || s1_rdy;

  assign in_if.ready   = s0_rdy;
  assign out_if.valid  = s3_valid_r;
  assign div_ctl.s2_en = s2_rdy && s1_valid_r;
  assign div_ctl.s3_en = s3_rdy && s2_valid_r;

  // Valid bits travel with the data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
    end else begin
      if (s0_rdy) s0_valid_r <= in_if.valid;
      if (s1_rdy) s1_valid_r <= s0_valid_r;
      if (s2_rdy) s2_valid_r <= s1_valid_r;
      if (s3_rdy) s3_valid_r <= s2_valid_r;
    end
  end

  rgbenv_cfg u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_if (cfg_if),
    .regs_o (cfg_regs)
  );

  rgbenv_phase u_phase (
    .clk    (clk),
    .en_i   (s0_rdy && in_if.valid),
    .life_i (in_if.life_position),
    .cfg_i  (cfg_regs),
    .data_o (phase_data)
  );

  rgbenv_mul u_mul (
    .clk     (clk),
    .en_i    (s1_rdy && s0_valid_r),
    .phase_i (phase_data),
    .data_o  (mul_data)
  );

  rgbenv_div u_div (
    .clk     (clk),
    .ctl_i   (div_ctl),
    .mul_i   (mul_data),
    .color_o (out_if.color_out)
  );

endmodule

`default_nettype wire

/* rtl/rgbenv_cfg.sv */
// Configuration register file of the color envelope interpolator.
// Depends on rgbenv_pkg and rgbenv_cfg_if.
`timescale 1ns / 1ps
`default_nettype none

module rgbenv_cfg (
  input  wire                    clk,
  input  wire                    rst_n,
  rgbenv_cfg_if.sink             cfg_if,
  output rgbenv_pkg::cfg_regs_t  regs_o
);
  import rgbenv_pkg::*;

  cfg_regs_t regs_r;
  cfg_regs_t regs_nxt;

  // Writes are always taken; an unknown index changes nothing.
  assign cfg_if.ready = 1'b1;

  always_comb begin
    regs_nxt = regs_r;
    if (cfg_if.valid) begin
      case (cfg_if.index)
        REG_START_COLOR:    regs_nxt.start_color    = cfg_if.data[COLOR_W-1:0];
        REG_PEAK_COLOR:     regs_nxt.peak_color     = cfg_if.data[COLOR_W-1:0];
        REG_END_COLOR:      regs_nxt.end_color      = cfg_if.data[COLOR_W-1:0];
        REG_FADE_IN_POINT:  regs_nxt.fade_in_point  = cfg_if.data[POS_W-1:0];
        REG_PEAK_POINT:     regs_nxt.peak_point     = cfg_if.data[POS_W-1:0];
        REG_FADE_OUT_POINT: regs_nxt.fade_out_point = cfg_if.data[POS_W-1:0];
        REG_INTERP_EN:      regs_nxt.interp_en      = cfg_if.data[0];
        default:            regs_nxt = regs_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.start_color    <= RST_START_COLOR;
      regs_r.peak_color     <= RST_PEAK_COLOR;
      regs_r.end_color      <= RST_END_COLOR;
      regs_r.fade_in_point  <= RST_FADE_IN_POINT;
      regs_r.peak_point     <= RST_PEAK_POINT;
      regs_r.fade_out_point <= RST_FADE_OUT_POINT;
      regs_r.interp_en      <= RST_INTERP_EN;
    end else begin
      regs_r <= regs_nxt;
    end
  end

  assign regs_o = regs_r;

endmodule

`default_nettype wire

/* rtl/rgbenv_phase.sv */
// Stage 0: picks the envelope phase for a life position and registers the
// segment endpoints, offset and span. Depends on rgbenv_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rgbenv_phase (
  input  wire                               clk,
  input  wire                               en_i,
  input  wire [rgbenv_pkg::POS_W-1:0]       life_i,
  input  rgbenv_pkg::cfg_regs_t             cfg_i,
  output rgbenv_pkg::phase_data_t           data_o
);
  import rgbenv_pkg::*;

  phase_data_t data_r;
  phase_data_t data_nxt;
  logic        below_in;
  logic        below_peak;
  logic        below_out;

  assign below_in   = life_i < cfg_i.fade_in_point;
  assign below_peak = life_i < cfg_i.peak_point;
  assign below_out  = life_i < cfg_i.fade_out_point;

  // A held color is sent on as base with a zero offset, so the later
  // stages add nothing to it; span is kept at one so the divider is sane.
  always_comb begin
    data_nxt.base   = cfg_i.end_color;
    data_nxt.target = cfg_i.end_color;
    data_nxt.off    = '0;
    data_nxt.span   = POS_W'(1);
    if (below_in) begin
      data_nxt.base   = cfg_i.start_color;
      data_nxt.target = cfg_i.start_color;
    end else if (below_peak) begin
      if (cfg_i.interp_en) begin
        data_nxt.base   = cfg_i.start_color;
        data_nxt.target = cfg_i.peak_color;
        data_nxt.off    = life_i - cfg_i.fade_in_point;
        data_nxt.span   = cfg_i.peak_point - cfg_i.fade_in_point;
      end else begin
        data_nxt.base   = cfg_i.peak_color;
        data_nxt.target = cfg_i.peak_color;
      end
    end else if (below_out) begin
      if (cfg_i.interp_en) begin
        data_nxt.base   = cfg_i.peak_color;
        data_nxt.target = cfg_i.end_color;
        data_nxt.off    = life_i - cfg_i.peak_point;
        data_nxt.span   = cfg_i.fade_out_point - cfg_i.peak_point;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en_i) begin
      data_r <= data_nxt;
    end
  end

  assign data_o = data_r;

endmodule

`default_nettype wire

/* rtl/rgbenv_mul.sv */
// Stage 1: per channel sign and magnitude of the color difference, times
// the offset into the segment. Depends on rgbenv_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rgbenv_mul (
  input  wire                        clk,
  input  wire                        en_i,
  input  rgbenv_pkg::phase_data_t    phase_i,
  output rgbenv_pkg::mul_data_t      data_o
);
  import rgbenv_pkg::*;

  mul_data_t data_r;
  mul_data_t data_nxt;

  // The quotient is formed on magnitudes; the sign is applied at the end,
  // which gives truncation toward zero.
  always_comb begin
    logic [CHAN_W-1:0] b;
    logic [CHAN_W-1:0] t;
    logic [CHAN_W-1:0] mag;
    data_nxt.span = phase_i.span;
    for (int c = 0; c < NUM_CHAN; c++) begin
      b   = phase_i.base[c*CHAN_W +: CHAN_W];
      t   = phase_i.target[c*CHAN_W +: CHAN_W];
      mag = (t < b) ? (b - t) : (t - b);
      data_nxt.ch[c].neg  = t < b;
      data_nxt.ch[c].base = b;
      data_nxt.ch[c].prod = PROD_W'(mag) * PROD_W'(phase_i.off);
    end
  end

  always_ff @(posedge clk) begin
    if (en_i) begin
      data_r <= data_nxt;
    end
  end

  assign data_o = data_r;

endmodule

`default_nettype wire

/* rtl/rgbenv_div.sv */
// Stages 2 and 3: restoring division of each product by the span, three
// quotient bits then two, and the signed add to the base channel.
// Depends on rgbenv_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rgbenv_div (
  input  wire                          clk,
  input  rgbenv_pkg::pipe_ctl_t        ctl_i,
  input  rgbenv_pkg::mul_data_t        mul_i,
  output wire [rgbenv_pkg::COLOR_W-1:0] color_o
);
  import rgbenv_pkg::*;

  div_data_t          s2_r;
  div_data_t          s2_nxt;
  logic [COLOR_W-1:0] color_r;
  logic [COLOR_W-1:0] color_nxt;

  // The quotient is below 32 because the offset is below the span, so five
  // restoring steps cover it. Quotient bits 4 to 2 are found here.
  always_comb begin
    logic [PROD_W-1:0] rem;
    logic [PROD_W-1:0] dvs;
    logic [2:0]        qh;
    s2_nxt.span = mul_i.span;
    for (int c = 0; c < NUM_CHAN; c++) begin
      rem = mul_i.ch[c].prod;
      qh  = '0;
      for (int k = 2; k >= 0; k--) begin
        dvs = PROD_W'(mul_i.span) << (k + 2);
        if (rem >= dvs) begin
          rem   = rem - dvs;
          qh[k] = 1'b1;
        end
      end
      s2_nxt.ch[c].neg  = mul_i.ch[c].neg;
      s2_nxt.ch[c].base = mul_i.ch[c].base;
      s2_nxt.ch[c].rem  = rem;
      s2_nxt.ch[c].q_hi = qh;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl_i.s2_en) begin
      s2_r <= s2_nxt;
    end
  end

  // Quotient bits 1 and 0, then base plus or minus the quotient. The result
  // lies between base and target, so five bits hold it.
  always_comb begin
    logic [PROD_W-1:0] rem;
    logic [PROD_W-1:0] dvs;
    logic [CHAN_W-1:0] q;
    color_nxt = '0;
    for (int c = 0; c < NUM_CHAN; c++) begin
      rem = s2_r.ch[c].rem;
      q   = {s2_r.ch[c].q_hi, 2'b00};
      for (int k = 1; k >= 0; k--) begin
        dvs = PROD_W'(s2_r.span) << k;
        if (rem >= dvs) begin
          rem  = rem - dvs;
          q[k] = 1'b1;
        end
      end
      color_nxt[c*CHAN_W +: CHAN_W] = s2_r.ch[c].neg ? (s2_r.ch[c].base - q)
                                                     : (s2_r.ch[c].base + q);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl_i.s3_en) begin
      color_r <= color_nxt;
    end
  end

  assign color_o = color_r;

endmodule

`default_nettype wire

/* rtl/rgbenv_checker.sv */
// Port-level checker of the color envelope interpolator, bound to the top
// level. Depends on rgbenv_pkg and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "rgb555_color_envelope_interpolator_core_macros.svh"

module rgbenv_checker (
  input wire                            clk,
  input wire                            rst_n,
  input wire                            in_valid,
  input wire                            in_ready,
  input wire                            out_valid,
  input wire                            out_ready,
  input wire [rgbenv_pkg::COLOR_W-1:0]  color_out
);
  import rgbenv_pkg::*;

  logic       in_acc;
  logic       out_acc;
  logic [2:0] occ_r;
  logic [2:0] occ_nxt;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  // Items accepted but not yet delivered.
  assign occ_nxt = occ_r + {2'b00, in_acc} - {2'b00, out_acc};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= '0;
    end else begin
      occ_r <= occ_nxt;
    end
  end

  `RGBENV_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(color_out), "stalled result changed or dropped")
  `RGBENV_ASSERT_IMP(a_no_phantom, clk, rst_n, out_acc, occ_r != 3'd0, "result delivered with no item in flight")
  `RGBENV_ASSERT_IMP(a_depth, clk, rst_n, 1'b1, occ_r <= 3'(PIPE_DEPTH), "more items in flight than pipeline stages")
  `RGBENV_ASSERT_IMP(a_empty_ready, clk, rst_n, occ_r == 3'd0, in_ready && !out_valid, "empty pipeline not ready or showing a result")

endmodule

bind rgb555_color_envelope_interpolator_core rgbenv_checker u_rgbenv_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_if.valid),
  .in_ready  (in_if.ready),
  .out_valid (out_if.valid),
  .out_ready (out_if.ready),
  .color_out (out_if.color_out)
);

`default_nettype wire
